// File: src/rvr_pkg.sv
package rvr_pkg;

  // Field widths of the request and result ports.
  localparam int DATA_W = 32;
  localparam int UNIT_W = 18;

  // Default binary point position of the Q-format request and result ports.
  localparam int FRAC_BITS_DEF = 16;

  // Angle reduction: magnitude, reciprocal product, quotient and remainder.
  localparam int ANGLE_RED_STAGES = 3;

  // Sine and cosine rotator.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;

  // Axis length square root and the three unit-axis dividers.
  localparam int ISQRT_STEPS = 32;
  localparam int ISQRT_PER_STAGE = 2;
  localparam int ISQRT_STAGES = ISQRT_STEPS / ISQRT_PER_STAGE;
  localparam int UDIV_STEPS = 32;
  localparam int UDIV_PER_STAGE = 2;
  localparam int UDIV_STAGES = UDIV_STEPS / UDIV_PER_STAGE;

  // Axis normalizer depth: five front stages, square root, divider setup,
  // divider and the output stage.
  localparam int NORM_LATENCY = ISQRT_STAGES + UDIV_STAGES + 7;

  // Rotation stages after the sine, cosine and unit axis meet.
  localparam int BACK_STAGES = 6;

  // Total depth of the sine and cosine unit: angle reduction, rotator input
  // stage, rotator stages and the quadrant stage.
  localparam int SINCOS_LATENCY = ANGLE_RED_STAGES + CORDIC_STAGES + 2;

  // Arctangent of 2^-i in 32-bit binary angle units.
  function automatic logic [31:0] atan_bam(input int idx);
    logic [31:0] val;
    case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      24: val = 32'd41;
      25: val = 32'd20;
      26: val = 32'd10;
      27: val = 32'd5;
      28: val = 32'd3;
      29: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// File: src/rvr_sincos.sv
module rvr_sincos #(
  parameter int FRAC_BITS = rvr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic signed [rvr_pkg::DATA_W-1:0] angle,
  output logic signed [rvr_pkg::DATA_W-1:0] cos_q30,
  output logic signed [rvr_pkg::DATA_W-1:0] sin_q30
);
  import rvr_pkg::*;

  localparam int SHIFT = 29 - FRAC_BITS;
  localparam int DIVISOR = 45;
  localparam int RECIP_SH = 37;
  localparam logic [31:0] RECIP_45 = 32'd3054198967;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cordic_t;

  cordic_t cordic_stage [CORDIC_STAGES+1];

  logic [DATA_W-1:0] ang_mag;
  logic              mag_neg;
  logic [DATA_W-1:0] mag_s;
  logic              prod_neg;
  logic [DATA_W-1:0] prod_mag;
  logic [63:0]       prod_s;
  logic [26:0]       quo_next;
  logic [5:0]        rem_next;
  logic              red_neg;
  logic [26:0]       red_quo;
  logic [5:0]        red_rem;
  logic [31:0]       frac_tab [DIVISOR];
  logic [31:0]       quo;
  logic [31:0]       phase;

  // Magnitude of the angle; turns in 2^32 are |angle| * 2^(29-FRAC_BITS) / 45.
  assign ang_mag = angle[DATA_W-1] ? DATA_W'(-angle) : DATA_W'(angle);

  always_ff @(posedge clk) begin
    mag_neg <= angle[DATA_W-1];
    mag_s   <= ang_mag;
  end

  // Reciprocal product; exact quotient by 45 for magnitudes up to 2^31.
  always_ff @(posedge clk) begin
    prod_neg <= mag_neg;
    prod_mag <= mag_s;
    prod_s   <= 64'(mag_s) * 64'(RECIP_45);
  end

  assign quo_next = prod_s[63:RECIP_SH];
  assign rem_next = 6'(prod_mag - 32'(quo_next) * 32'(DIVISOR));

  always_ff @(posedge clk) begin
    red_neg <= prod_neg;
    red_quo <= quo_next;
    red_rem <= rem_next;
  end

  // Quotient bits that the scaled remainder contributes, one entry per remainder.
  for (genvar r = 0; r < DIVISOR; r++) begin : g_frac
    assign frac_tab[r] = 32'((r << SHIFT) / DIVISOR);
  end

  // Since 45 is odd, the scaled division is exact only when the remainder is zero.
  // Floor division of a negative angle rounds away from zero when a remainder is left.
  assign quo = 32'(64'(red_quo) << SHIFT) + frac_tab[red_rem];
  always_comb begin
    if (red_neg) begin
      phase = 32'd0 - quo - {31'd0, red_rem != 6'd0};
    end else begin
      phase = quo;
    end
  end

  always_ff @(posedge clk) begin
    cordic_stage[0].quad <= phase[31:30];
    cordic_stage[0].x    <= CORDIC_GAIN;
    cordic_stage[0].y    <= 34'sd0;
    cordic_stage[0].z    <= $signed({3'b000, phase[29:0]});
  end

  // Rotation steps toward zero residual angle.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    cordic_t cordic_next;
    always_comb begin
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] z;
      logic signed [32:0] step;
      x = cordic_stage[g].x;
      y = cordic_stage[g].y;
      z = cordic_stage[g].z;
      for (int s = 0; s < CORDIC_PER_STAGE; s++) begin
        dx = y >>> (g * CORDIC_PER_STAGE + s);
        dy = x >>> (g * CORDIC_PER_STAGE + s);
        step = $signed({1'b0, atan_bam(g * CORDIC_PER_STAGE + s)});
        if (!z[32]) begin
          x = x - dx;
          y = y + dy;
          z = z - step;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + step;
        end
      end
      cordic_next.quad = cordic_stage[g].quad;
      cordic_next.x = x;
      cordic_next.y = y;
      cordic_next.z = z;
    end
    always_ff @(posedge clk) begin
      cordic_stage[g+1] <= cordic_next;
    end
  end

  // Quadrant correction and clamp to plus or minus one.
  always_ff @(posedge clk) begin
    logic signed [33:0] c;
    logic signed [33:0] s;
    logic signed [33:0] x;
    logic signed [33:0] y;
    x = cordic_stage[CORDIC_STAGES].x;
    y = cordic_stage[CORDIC_STAGES].y;
    case (cordic_stage[CORDIC_STAGES].quad)
      QUAD_1: begin
        c = -y;
        s = x;
      end
      QUAD_2: begin
        c = -x;
        s = -y;
      end
      QUAD_3: begin
        c = y;
        s = -x;
      end
      QUAD_0: begin
        c = x;
        s = y;
      end
      default: begin
        c = x;
        s = y;
      end
    endcase
    if (c > Q30_ONE) c = Q30_ONE;
    if (c < -Q30_ONE) c = -Q30_ONE;
    if (s > Q30_ONE) s = Q30_ONE;
    if (s < -Q30_ONE) s = -Q30_ONE;
    cos_q30 <= DATA_W'(c);
    sin_q30 <= DATA_W'(s);
  end

endmodule

// File: src/rvr_norm.sv
module rvr_norm (
  input  logic                              clk,
  input  logic signed [rvr_pkg::DATA_W-1:0] axis_in [3],
  output logic signed [rvr_pkg::DATA_W-1:0] unit_k  [3],
  output logic                              zero_len
);
  import rvr_pkg::*;

  localparam logic [31:0] UNIT_ONE = 32'd1 << 30;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [31:0]      mx;
  } abs_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][31:0] mag;
    logic [4:0]       pos;
  } lead_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mn;
  } scaled_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mn;
    logic [2:0][59:0] sq;
  } square_t;

  typedef struct packed {
    logic [63:0]      n;
    logic [63:0]      r;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mn;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][31:0] work;
    logic [31:0]      len;
    logic [2:0]       neg;
    logic             zero;
  } div_t;

  abs_t    abs_s;
  abs_t    abs_next;
  lead_t   lead_s;
  scaled_t scaled_s;
  square_t square_s;
  sqrt_t   sqrt_s [ISQRT_STAGES+1];
  div_t    div_s  [UDIV_STAGES+1];

  // Component magnitudes and their largest.
  always_comb begin
    abs_next.mx = 32'd0;
    for (int i = 0; i < 3; i++) begin
      abs_next.neg[i] = axis_in[i][DATA_W-1];
      abs_next.mag[i] = axis_in[i][DATA_W-1] ? 32'(-axis_in[i]) : 32'(axis_in[i]);
      if (abs_next.mag[i] > abs_next.mx) abs_next.mx = abs_next.mag[i];
    end
  end

  always_ff @(posedge clk) begin
    abs_s <= abs_next;
  end

  // Leading one of the largest magnitude.
  always_ff @(posedge clk) begin
    logic [4:0] pos;
    pos = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (abs_s.mx[b]) pos = 5'(b);
    end
    lead_s.neg  <= abs_s.neg;
    lead_s.zero <= (abs_s.mx == 32'd0);
    lead_s.mag  <= abs_s.mag;
    lead_s.pos  <= pos;
  end

  // Common shift that brings the largest magnitude into [2^29, 2^30).
  always_ff @(posedge clk) begin
    logic [60:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = {lead_s.mag[i], 29'd0} >> lead_s.pos;
      scaled_s.mn[i] <= wide[29:0];
    end
    scaled_s.neg  <= lead_s.neg;
    scaled_s.zero <= lead_s.zero;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      square_s.sq[i] <= scaled_s.mn[i] * scaled_s.mn[i];
    end
    square_s.mn   <= scaled_s.mn;
    square_s.neg  <= scaled_s.neg;
    square_s.zero <= scaled_s.zero;
  end

  // Squared length feeds the square root.
  always_ff @(posedge clk) begin
    sqrt_s[0].n    <= 64'(square_s.sq[0]) + 64'(square_s.sq[1]) + 64'(square_s.sq[2]);
    sqrt_s[0].r    <= 64'd0;
    sqrt_s[0].neg  <= square_s.neg;
    sqrt_s[0].zero <= square_s.zero;
    sqrt_s[0].mn   <= square_s.mn;
  end

  // Digit-by-digit integer square root, one result bit per step.
  for (genvar g = 0; g < ISQRT_STAGES; g++) begin : g_sqrt
    sqrt_t sqrt_next;
    always_comb begin
      logic [63:0] bit_w;
      sqrt_next = sqrt_s[g];
      for (int s = 0; s < ISQRT_PER_STAGE; s++) begin
        bit_w = 64'd1 << (62 - 2 * (g * ISQRT_PER_STAGE + s));
        if (sqrt_next.n >= sqrt_next.r + bit_w) begin
          sqrt_next.n = sqrt_next.n - (sqrt_next.r + bit_w);
          sqrt_next.r = (sqrt_next.r >> 1) + bit_w;
        end else begin
          sqrt_next.r = sqrt_next.r >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      sqrt_s[g+1] <= sqrt_next;
    end
  end

  // Rounded dividends for the three unit components.
  always_ff @(posedge clk) begin
    logic [31:0] len;
    logic [60:0] num;
    len = sqrt_s[ISQRT_STAGES].r[31:0];
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sqrt_s[ISQRT_STAGES].mn[i], 30'd0} + 61'(len >> 1);
      div_s[0].rem[i]  <= 32'(num[60:32]);
      div_s[0].work[i] <= num[31:0];
    end
    div_s[0].len  <= len;
    div_s[0].neg  <= sqrt_s[ISQRT_STAGES].neg;
    div_s[0].zero <= sqrt_s[ISQRT_STAGES].zero;
  end

  // Restoring division by the length; quotient bits fill the work word.
  for (genvar g = 0; g < UDIV_STAGES; g++) begin : g_udiv
    div_t div_next;
    always_comb begin
      logic [32:0] trial;
      div_next = div_s[g];
      for (int s = 0; s < UDIV_PER_STAGE; s++) begin
        for (int i = 0; i < 3; i++) begin
          trial = {div_next.rem[i], div_next.work[i][31]};
          div_next.work[i] = {div_next.work[i][30:0], 1'b0};
          if (trial >= {1'b0, div_next.len}) begin
            div_next.rem[i] = 32'(trial - {1'b0, div_next.len});
            div_next.work[i][0] = 1'b1;
          end else begin
            div_next.rem[i] = trial[31:0];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      div_s[g+1] <= div_next;
    end
  end

  // Cap at one, restore signs, and force zero for a zero-length axis.
  always_ff @(posedge clk) begin
    logic [31:0] u;
    for (int i = 0; i < 3; i++) begin
      u = div_s[UDIV_STAGES].work[i];
      if (u > UNIT_ONE) u = UNIT_ONE;
      if (div_s[UDIV_STAGES].zero) begin
        unit_k[i] <= '0;
      end else if (div_s[UDIV_STAGES].neg[i]) begin
        unit_k[i] <= -$signed(u);
      end else begin
        unit_k[i] <= $signed(u);
      end
    end
    zero_len <= div_s[UDIV_STAGES].zero;
  end

endmodule

// File: src/rodrigues_vector_rotation.sv
// Rotates a Q16.16 vector about an arbitrary axis by an angle in degrees, using
// v*cos + (k x v)*sin + k*(k.v)*(1-cos) with k the normalized axis. One request is
// taken every clock cycle (busy stays low) and its result appears on the result ports,
// marked by done for one cycle. The pipeline depth is set by the axis normalizer: a
// 16-stage square root and a 16-stage divider, two bits per stage, followed by six
// stages of products and sums; the sine and cosine path is shorter and is delayed to
// match. The receiver cannot stall, so results must be taken when done is high. A
// zero-length axis gives a zero unit axis, sets axis_zero, and reduces the result to
// the vector times the cosine; rotated components saturate.
module rodrigues_vector_rotation #(
  parameter int FRAC_BITS = rvr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rvr_pkg::DATA_W-1:0] angle_degrees,
  input  logic signed [rvr_pkg::DATA_W-1:0] vector_x,
  input  logic signed [rvr_pkg::DATA_W-1:0] vector_y,
  input  logic signed [rvr_pkg::DATA_W-1:0] vector_z,
  input  logic signed [rvr_pkg::DATA_W-1:0] axis_x,
  input  logic signed [rvr_pkg::DATA_W-1:0] axis_y,
  input  logic signed [rvr_pkg::DATA_W-1:0] axis_z,
  output logic                              done,
  output logic signed [rvr_pkg::DATA_W-1:0] rotated_x,
  output logic signed [rvr_pkg::DATA_W-1:0] rotated_y,
  output logic signed [rvr_pkg::DATA_W-1:0] rotated_z,
  output logic signed [rvr_pkg::UNIT_W-1:0] unit_axis_x,
  output logic signed [rvr_pkg::UNIT_W-1:0] unit_axis_y,
  output logic signed [rvr_pkg::UNIT_W-1:0] unit_axis_z,
  output logic                              axis_zero
);
  import rvr_pkg::*;

  localparam int SC_LAT = SINCOS_LATENCY;
  localparam int SC_DLY = NORM_LATENCY - SC_LAT;
  localparam int LAT_TOTAL = NORM_LATENCY + BACK_STAGES;
  localparam int USH = 30 - FRAC_BITS;
  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;
  localparam logic signed [67:0] D_MIN = -(68'sd1 <<< 32);
  localparam logic signed [67:0] D_MAX = (68'sd1 <<< 32) - 68'sd1;
  localparam logic signed [67:0] OUT_MIN = -(68'sd1 <<< 31);
  localparam logic signed [67:0] OUT_MAX = (68'sd1 <<< 31) - 68'sd1;

  function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
    return (v + 68'sd536870912) >>> 30;
  endfunction

  logic                     take;
  logic [LAT_TOTAL-1:0]     vld;
  logic signed [DATA_W-1:0] axis_in  [3];
  logic signed [DATA_W-1:0] unit_k   [3];
  logic                     zero_len;
  logic signed [DATA_W-1:0] cos_q30;
  logic signed [DATA_W-1:0] sin_q30;
  logic signed [DATA_W-1:0] cs_dly   [SC_DLY];
  logic signed [DATA_W-1:0] sn_dly   [SC_DLY];
  logic signed [DATA_W-1:0] vec_dly  [NORM_LATENCY][3];

  logic signed [63:0] b1_kv [3][3];
  logic signed [63:0] b1_vc [3];
  logic signed [32:0] b1_omc;
  logic signed [31:0] b1_sn;
  logic signed [31:0] b1_k  [3];
  logic               b1_zero;

  logic signed [67:0] dot_next;
  logic signed [32:0] b2_d;
  logic signed [33:0] b2_cr  [3];
  logic signed [32:0] b2_vcr [3];
  logic signed [32:0] b2_omc;
  logic signed [31:0] b2_sn;
  logic signed [31:0] b2_k   [3];
  logic               b2_zero;

  logic signed [65:0] b3_pm;
  logic signed [65:0] b3_crs [3];
  logic signed [32:0] b3_vcr [3];
  logic signed [31:0] b3_k   [3];
  logic               b3_zero;

  logic signed [35:0] b4_p;
  logic signed [33:0] b4_crsr [3];
  logic signed [32:0] b4_vcr  [3];
  logic signed [31:0] b4_k    [3];
  logic               b4_zero;

  logic signed [67:0] b5_kp   [3];
  logic signed [33:0] b5_crsr [3];
  logic signed [32:0] b5_vcr  [3];
  logic signed [31:0] b5_k    [3];
  logic               b5_zero;

  logic signed [67:0]     sum_next  [3];
  logic signed [31:0]     rot_next  [3];
  logic [UNIT_W-1:0]      unit_next [3];

  // The pipeline never stalls, so a request is taken whenever start is high.
  assign busy = 1'b0;
  assign take = start && !busy;

  // Valid bits travel alongside the data pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT_TOTAL-2:0], take};
    end
  end

  assign done = vld[LAT_TOTAL-1];

  assign axis_in[0] = axis_x;
  assign axis_in[1] = axis_y;
  assign axis_in[2] = axis_z;

  rvr_sincos #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sincos (
    .clk     (clk),
    .angle   (angle_degrees),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  rvr_norm u_norm (
    .clk      (clk),
    .axis_in  (axis_in),
    .unit_k   (unit_k),
    .zero_len (zero_len)
  );

  // Align sine, cosine and the vector with the unit axis.
  always_ff @(posedge clk) begin
    cs_dly[0] <= cos_q30;
    sn_dly[0] <= sin_q30;
    for (int i = 1; i < SC_DLY; i++) begin
      cs_dly[i] <= cs_dly[i-1];
      sn_dly[i] <= sn_dly[i-1];
    end
    vec_dly[0][0] <= vector_x;
    vec_dly[0][1] <= vector_y;
    vec_dly[0][2] <= vector_z;
    for (int i = 1; i < NORM_LATENCY; i++) begin
      vec_dly[i] <= vec_dly[i-1];
    end
  end

  // Products of the unit axis with the vector, and the vector with the cosine.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        b1_kv[i][j] <= unit_k[i] * vec_dly[NORM_LATENCY-1][j];
      end
      b1_vc[i] <= vec_dly[NORM_LATENCY-1][i] * cs_dly[SC_DLY-1];
    end
    b1_omc  <= Q30_ONE - cs_dly[SC_DLY-1];
    b1_sn   <= sn_dly[SC_DLY-1];
    b1_k    <= unit_k;
    b1_zero <= zero_len;
  end

  // Dot and cross products, each summed in full and rounded once.
  always_comb begin
    dot_next = rnd30(b1_kv[0][0] + b1_kv[1][1] + b1_kv[2][2]);
    if (dot_next < D_MIN) dot_next = D_MIN;
    if (dot_next > D_MAX) dot_next = D_MAX;
  end

  always_ff @(posedge clk) begin
    b2_d     <= 33'(dot_next);
    b2_cr[0] <= 34'(rnd30(b1_kv[1][2] - b1_kv[2][1]));
    b2_cr[1] <= 34'(rnd30(b1_kv[2][0] - b1_kv[0][2]));
    b2_cr[2] <= 34'(rnd30(b1_kv[0][1] - b1_kv[1][0]));
    for (int i = 0; i < 3; i++) begin
      b2_vcr[i] <= 33'(rnd30(b1_vc[i]));
    end
    b2_omc  <= b1_omc;
    b2_sn   <= b1_sn;
    b2_k    <= b1_k;
    b2_zero <= b1_zero;
  end

  always_ff @(posedge clk) begin
    b3_pm <= b2_d * b2_omc;
    for (int i = 0; i < 3; i++) begin
      b3_crs[i] <= b2_cr[i] * b2_sn;
    end
    b3_vcr  <= b2_vcr;
    b3_k    <= b2_k;
    b3_zero <= b2_zero;
  end

  always_ff @(posedge clk) begin
    b4_p <= 36'(rnd30(b3_pm));
    for (int i = 0; i < 3; i++) begin
      b4_crsr[i] <= 34'(rnd30(b3_crs[i]));
    end
    b4_vcr  <= b3_vcr;
    b4_k    <= b3_k;
    b4_zero <= b3_zero;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b5_kp[i] <= b4_k[i] * b4_p;
    end
    b5_crsr <= b4_crsr;
    b5_vcr  <= b4_vcr;
    b5_k    <= b4_k;
    b5_zero <= b4_zero;
  end

  // Sum of the three terms with saturation, and the unit axis at the port precision.
  always_comb begin
    logic [31:0] umag;
    logic [31:0] urnd;
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = b5_vcr[i] + b5_crsr[i] + rnd30(b5_kp[i]);
      if (sum_next[i] < OUT_MIN) begin
        rot_next[i] = 32'(OUT_MIN);
      end else if (sum_next[i] > OUT_MAX) begin
        rot_next[i] = 32'(OUT_MAX);
      end else begin
        rot_next[i] = 32'(sum_next[i]);
      end
      umag = b5_k[i][31] ? 32'(-b5_k[i]) : 32'(b5_k[i]);
      urnd = (umag + (32'd1 << (USH - 1))) >> USH;
      unit_next[i] = b5_k[i][31] ? UNIT_W'(32'd0 - urnd) : UNIT_W'(urnd);
    end
  end

  always_ff @(posedge clk) begin
    rotated_x   <= rot_next[0];
    rotated_y   <= rot_next[1];
    rotated_z   <= rot_next[2];
    unit_axis_x <= unit_next[0];
    unit_axis_y <= unit_next[1];
    unit_axis_z <= unit_next[2];
    axis_zero   <= b5_zero;
  end

endmodule
